// ===== rtl/ps2md_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2md_pkg
// Types and constants shared by the PS/2 mouse packet decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2md_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned MOVE_X_W   = 9;
	localparam int unsigned MOVE_Y_W   = 10;
	localparam int unsigned POS_W      = 32;
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	// header flag positions
	localparam int unsigned HDR_SYNC  = 3;
	localparam int unsigned HDR_X_SGN = 4;
	localparam int unsigned HDR_Y_SGN = 5;
	localparam int unsigned HDR_X_OVF = 6;
	localparam int unsigned HDR_Y_OVF = 7;

	localparam logic [BYTE_W-1:0] OVF_MAG = 8'd128;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_X      = 2'd1,
		PH_Y      = 2'd2
	} phase_t;

	// one complete packet, as handed from front to back
	typedef struct packed {
		logic [BYTE_W-1:0] hdr;
		logic [BYTE_W-1:0] x;
		logic [BYTE_W-1:0] y;
	} pkt_t;

	// queue handshake seen from either side
	typedef struct packed {
		logic valid;
		pkt_t pkt;
	} pkt_req_t;

endpackage

`default_nettype wire

// ===== rtl/ps2md_if.sv =====
// ----------------------------------------------------------------------------
// ps2md_if
// Valid/ready channels: received byte in, decoded movement word out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ps2md_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ps2md_move_if;
	logic               valid;
	logic               ready;
	logic signed [8:0]  move_x;
	logic signed [9:0]  move_y_screen;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;

	modport source (output valid, output move_x, output move_y_screen,
		output pos_x, output pos_y, input ready);
	modport sink   (input valid, input move_x, input move_y_screen,
		input pos_x, input pos_y, output ready);
endinterface

`default_nettype wire

// ===== rtl/ps2_mouse_packet_decoder.sv =====
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder
// Three-byte PS/2 mouse packet decoder with wrapping X/Y position tracking.
// ----------------------------------------------------------------------------
// Usage
//   rx     : one byte from the mouse auxiliary port per word (valid/ready).
//   report : one word per complete packet - move_x, move_y_screen (Y negated
//            for screen direction) and the 32-bit wrapping positions.
//   While hunting for a header, bytes with bit 3 clear are dropped silently.
// Throughput: one byte per cycle, sustained, with the receiver taking words.
// Path: the third byte of a packet is written into the packet queue, and its
//   report word is then loaded into the output register when it is popped.
// Stall: a stalled receiver holds the output register; the two-entry packet
//   queue fills, then rx.ready drops, but only while the third byte of a
//   packet is pending - header and X bytes are still taken.
// Reset (arst_n low): phase back to header hunt, positions cleared to zero,
//   queue emptied, no word pending. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_mouse_packet_decoder #(
	parameter int unsigned QUEUE_DEPTH = ps2md_pkg::QUEUE_DEPTH_DEF
) (
	input  wire           clk,
	input  wire           arst_n,
	ps2md_byte_if.sink    rx,
	ps2md_move_if.source  report
);
	import ps2md_pkg::*;

	pkt_req_t push;     // front -> queue
	pkt_req_t head;     // queue -> back
	logic     q_full;
	logic     pop;

	// framing: header sync and packet assembly
	ps2md_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_byte  (rx.rx_byte),
		.in_ready (rx.ready),
		.push     (push),
		.q_full   (q_full)
	);

	// decouples framing from the output stall
	ps2md_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	// movement arithmetic and accumulators
	ps2md_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.mv     (report)
	);

endmodule

`default_nettype wire

// ===== rtl/ps2md_front.sv =====
// ----------------------------------------------------------------------------
// ps2md_front
// Byte framing: header sync, packet assembly, push into the packet queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2md_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  wire [7:0]           in_byte,
	output logic                in_ready,
	output ps2md_pkg::pkt_req_t push,
	input  wire                 q_full
);
	import ps2md_pkg::*;

	phase_t            phase_q;
	logic [BYTE_W-1:0] hdr_q;
	logic [BYTE_W-1:0] x_q;
	logic              take;

	// only the third byte needs room in the queue
	assign in_ready = (phase_q != PH_Y) || !q_full;
	assign take     = in_valid && in_ready;

	assign push.valid   = take && (phase_q == PH_Y);
	assign push.pkt.hdr = hdr_q;
	assign push.pkt.x   = x_q;
	assign push.pkt.y   = in_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hdr_q   <= '0;
			x_q     <= '0;
		end else if (take) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (in_byte[HDR_SYNC]) begin
						hdr_q   <= in_byte;
						phase_q <= PH_X;
					end
				end
				PH_X: begin
					x_q     <= in_byte;
					phase_q <= PH_Y;
				end
				default: phase_q <= PH_HEADER;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ps2md_queue.sv =====
// ----------------------------------------------------------------------------
// ps2md_queue
// Short packet FIFO between framing and movement arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2md_queue #(
	parameter int unsigned DEPTH = ps2md_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  ps2md_pkg::pkt_req_t push,
	output logic                full,
	output ps2md_pkg::pkt_req_t head,
	input  wire                 pop
);
	import ps2md_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	pkt_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (cnt_q == FULL_CNT);
	assign head.valid = (cnt_q != '0);
	assign head.pkt   = mem_q[rd_q];
	assign do_push  = push.valid && !full;
	assign do_pop   = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push.pkt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ps2md_back.sv =====
// ----------------------------------------------------------------------------
// ps2md_back
// Movement decode, position accumulation and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2md_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  ps2md_pkg::pkt_req_t head,
	output logic                pop,
	ps2md_move_if.source        mv
);
	import ps2md_pkg::*;

	logic                       out_valid_q;
	logic signed [MOVE_X_W-1:0] move_x_q;
	logic signed [MOVE_Y_W-1:0] move_y_q;
	logic signed [POS_W-1:0]    pos_x_q;
	logic signed [POS_W-1:0]    pos_y_q;

	logic [BYTE_W-1:0]          mag_x;
	logic [BYTE_W-1:0]          mag_y;
	logic signed [MOVE_X_W-1:0] dx;
	logic signed [MOVE_X_W-1:0] dy;

	// overflow forces 128 first; sign then takes 256 off, i.e. sign bit on top
	always_comb begin
		mag_x = head.pkt.hdr[HDR_X_OVF] ? OVF_MAG : head.pkt.x;
		mag_y = head.pkt.hdr[HDR_Y_OVF] ? OVF_MAG : head.pkt.y;
		dx    = {head.pkt.hdr[HDR_X_SGN], mag_x};
		dy    = {head.pkt.hdr[HDR_Y_SGN], mag_y};
	end

	assign pop = head.valid && (!out_valid_q || mv.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				pos_x_q     <= pos_x_q + POS_W'(dx);
				pos_y_q     <= pos_y_q - POS_W'(dy);
			end else if (mv.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			move_x_q <= dx;
			move_y_q <= -MOVE_Y_W'(dy);
		end
	end

	assign mv.valid         = out_valid_q;
	assign mv.move_x        = move_x_q;
	assign mv.move_y_screen = move_y_q;
	assign mv.pos_x         = pos_x_q;
	assign mv.pos_y         = pos_y_q;

endmodule

`default_nettype wire

// ===== verif/tb_ps2_mouse_packet_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_ps2_mouse_packet_decoder
// Self-checking bench for the PS/2 mouse packet decoder. A byte-level tracker
// predicts each movement word from the accepted rx bytes. Returned words are
// checked field by field, in order. Stimulus is a directed set of corner
// packets followed by mostly well-formed random packets, with noise and
// truncated packets mixed in. The sender works in bursts and the receiver
// stalls on its own pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_decoder;

	import ps2md_pkg::*;

	localparam int SIGN_OFFSET = 256;
	localparam int RANDOM_BYTES = 850;
	localparam int SETTLE_CYCLES = 10;

	// one pending rx word, or a marker telling the sender to wait for the
	// decoder to drain
	typedef struct {
		bit               hold_for_drain;
		logic [BYTE_W-1:0] data;
	} rx_item_t;

	typedef struct {
		logic signed [MOVE_X_W-1:0] move_x;
		logic signed [MOVE_Y_W-1:0] move_y_screen;
		logic signed [POS_W-1:0]    pos_x;
		logic signed [POS_W-1:0]    pos_y;
	} move_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ps2md_byte_if byte_ch ();
	ps2md_move_if move_ch ();

	ps2_mouse_packet_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (byte_ch),
		.report (move_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Packet tracker: mirrors the decoder's byte phase and positions
	// ------------------------------------------------------------------------
	rx_item_t   pending_bytes[$];
	move_word_t expected_moves[$];

	phase_t                  trk_phase = PH_HEADER;
	logic [BYTE_W-1:0]       trk_hdr = '0;
	logic [BYTE_W-1:0]       trk_x = '0;
	logic signed [POS_W-1:0] trk_pos_x = '0;
	logic signed [POS_W-1:0] trk_pos_y = '0;

	int  mismatch_count = 0;
	bit  byte_taken = 1'b0;

	// overflow forces the magnitude first, the sign then subtracts 256
	function automatic int axis_delta(input logic [BYTE_W-1:0] data, input logic ovf,
		input logic neg);
		int v;
		v = int'(data);
		if (ovf)
			v = int'(OVF_MAG);
		if (neg)
			v -= SIGN_OFFSET;
		return v;
	endfunction

	task automatic track_byte(input logic [BYTE_W-1:0] b);
		int         dx;
		int         dy;
		int         dy_screen;
		move_word_t w;
		case (trk_phase)
			PH_HEADER: begin
				// hunting for sync: bytes without bit 3 vanish
				if (b[HDR_SYNC]) begin
					trk_hdr = b;
					trk_phase = PH_X;
				end
			end
			PH_X: begin
				trk_x = b;
				trk_phase = PH_Y;
			end
			default: begin
				dx = axis_delta(trk_x, trk_hdr[HDR_X_OVF], trk_hdr[HDR_X_SGN]);
				dy = axis_delta(b, trk_hdr[HDR_Y_OVF], trk_hdr[HDR_Y_SGN]);
				dy_screen = -dy;
				trk_pos_x += dx;	// 32-bit wrap
				trk_pos_y -= dy;
				w.move_x = dx[MOVE_X_W-1:0];
				w.move_y_screen = dy_screen[MOVE_Y_W-1:0];
				w.pos_x = trk_pos_x;
				w.pos_y = trk_pos_y;
				expected_moves.push_back(w);
				trk_phase = PH_HEADER;
			end
		endcase
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------------
	// Monitor: both handshakes sampled at the rising edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		move_word_t w;
		byte_taken = byte_ch.valid && byte_ch.ready;
		if (arst_n && move_ch.valid && move_ch.ready) begin
			if (expected_moves.size() == 0) begin
				report_mismatch("unexpected word (move_x)", move_ch.move_x, 0);
			end else begin
				w = expected_moves.pop_front();
				if (move_ch.move_x !== w.move_x)
					report_mismatch("move_x", move_ch.move_x, w.move_x);
				if (move_ch.move_y_screen !== w.move_y_screen)
					report_mismatch("move_y_screen", move_ch.move_y_screen,
						w.move_y_screen);
				if (move_ch.pos_x !== w.pos_x)
					report_mismatch("pos_x", move_ch.pos_x, w.pos_x);
				if (move_ch.pos_y !== w.pos_y)
					report_mismatch("pos_y", move_ch.pos_y, w.pos_y);
			end
		end
		// predict after checking, so an older word is always at the front
		if (arst_n && byte_taken) begin
			track_byte(byte_ch.rx_byte);
			void'(pending_bytes.pop_front());
		end
	end

	// ------------------------------------------------------------------------
	// Sender: bursts of random length, gaps of random length, driven on the
	// falling edge. A drain marker at the head holds it off until every
	// expected word is back.
	// ------------------------------------------------------------------------
	int burst_left = 0;
	int gap_left = 0;

	always @(negedge clk) begin
		logic              nxt_valid;
		logic [BYTE_W-1:0] nxt_byte;
		int                r;
		if (arst_n) begin
			nxt_valid = 1'b0;
			nxt_byte = byte_ch.rx_byte;
			if (byte_ch.valid && !byte_taken) begin
				nxt_valid = 1'b1;	// word still on offer, hold it
			end else begin
				if (pending_bytes.size() > 0 && pending_bytes[0].hold_for_drain &&
					expected_moves.size() == 0)
					void'(pending_bytes.pop_front());
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_bytes.size() > 0 && !pending_bytes[0].hold_for_drain) begin
					nxt_valid = 1'b1;
					nxt_byte = pending_bytes[0].data;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						r = $urandom_range(0, 7);
						if (r < 3)
							gap_left = 0;
						else if (r < 7)
							gap_left = $urandom_range(1, 4);
						else
							gap_left = $urandom_range(8, 30);
					end
				end
			end
			byte_ch.valid <= nxt_valid;
			byte_ch.rx_byte <= nxt_byte;
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: ready steps through the bits of a random 8-bit mask, re-rolled
	// whenever stall_cnt runs out; an all-ones mask gives stretches with no stall
	// ------------------------------------------------------------------------
	int         stall_cnt = 0;
	logic [7:0] stall_mask = 8'hFF;

	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_cnt == 0) begin
				stall_mask = 8'($urandom);
				if ($urandom_range(0, 3) == 0)
					stall_mask = 8'hFF;
				if (stall_mask == 8'h00)
					stall_mask = 8'h01;
				stall_cnt = 64;
			end
			stall_cnt--;
			move_ch.ready <= stall_mask[stall_cnt % 8];
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	task automatic push_byte(input logic [BYTE_W-1:0] b);
		rx_item_t it;
		it.hold_for_drain = 1'b0;
		it.data = b;
		pending_bytes.push_back(it);
	endtask

	task automatic push_packet(input logic [BYTE_W-1:0] hdr, input logic [BYTE_W-1:0] x,
		input logic [BYTE_W-1:0] y);
		push_byte(hdr);
		push_byte(x);
		push_byte(y);
	endtask

	task automatic push_drain();
		rx_item_t it;
		it.hold_for_drain = 1'b1;
		it.data = '0;
		pending_bytes.push_back(it);
	endtask

	// data bytes lean towards the ends of the range
	function automatic logic [BYTE_W-1:0] pick_data();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			3: return 8'h7F;
			default: return BYTE_W'($urandom);
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] pick_header();
		logic [BYTE_W-1:0] h;
		h = BYTE_W'($urandom);
		h[HDR_SYNC] = 1'b1;
		return h;
	endfunction

	initial begin
		int n;
		byte_ch.valid = 1'b0;
		byte_ch.rx_byte = '0;
		move_ch.ready = 1'b0;

		// directed: dropped non-sync bytes, then the corner packets
		push_byte(8'h00);
		push_byte(8'hF7);	// every bit but sync
		push_packet(8'h08, 8'h00, 8'h00);
		push_packet(8'h08, 8'hFF, 8'hFF);
		push_packet(8'h38, 8'h00, 8'h00);	// both signs, zero data: -256
		push_packet(8'h38, 8'hFF, 8'hFF);	// both signs: -1
		push_packet(8'hC8, 8'h05, 8'h07);	// overflow alone: 128
		push_packet(8'hF8, 8'h05, 8'h07);	// overflow with sign: -128
		push_packet(8'hFF, 8'h12, 8'h34);
		push_drain();

		// random: mostly whole packets, some noise and truncated packets
		n = 0;
		while (n < RANDOM_BYTES) begin
			case ($urandom_range(0, 9))
				0: begin
					push_byte(BYTE_W'($urandom));
					n += 1;
				end
				1: begin
					push_byte(pick_header());
					push_byte(pick_data());
					n += 2;
				end
				default: begin
					push_packet(pick_header(), pick_data(), pick_data());
					n += 3;
				end
			endcase
			if ($urandom_range(0, 99) == 0)
				push_drain();
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_bytes.size() > 0 || expected_moves.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (expected_moves.size() > 0)
			report_mismatch("missing words", 0, expected_moves.size());

		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/ps2md_pkg.sv
rtl/ps2md_if.sv
rtl/ps2md_front.sv
rtl/ps2md_queue.sv
rtl/ps2md_back.sv
rtl/ps2_mouse_packet_decoder.sv
verif/tb_ps2_mouse_packet_decoder.sv
